@@ hw/rtl/sic_pkg.sv @@
// Shared types and constants for the sightline intersection counter.
`default_nettype none

package sic_pkg;

    localparam int MUL_W  = 32;            // shared multiplier operand width
    localparam int PROD_W = 2 * MUL_W;     // registered product width
    localparam int RAD_W  = 48;            // h (Q16.16) times scale (Q4.12)
    localparam int HALF_W = RAD_W / 2;     // radius split for squaring
    localparam int ACC_W  = 2 * RAD_W + 2; // signed rad^2 - offset sum
    localparam int DATA_W = 32;
    localparam int SCALE_W = 16;
    localparam int AXIS_W = 2;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER_FIRST    = 3'd0,
        CFG_CENTER_SECOND   = 3'd1,
        CFG_FIRST_AXIS      = 3'd2,
        CFG_SECOND_AXIS     = 3'd3,
        CFG_BOX_FIRST       = 3'd4,
        CFG_BOX_SECOND      = 3'd5,
        CFG_WRAP_ENABLE     = 3'd6,
        CFG_SMOOTHING_SCALE = 3'd7
    } cfg_idx_t;

    localparam logic [AXIS_W-1:0]  AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0]  AXIS_Y = 2'd1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd7478;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_24,
        SH_25,
        SH_48
    } acc_sh_t;

    typedef struct packed {
        acc_op_t op;
        acc_sh_t sh;
    } mac_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/sightline_particle_intersect_count.sv @@
// Top level: sightline intersection test and saturating hit counter.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_valid / s_ready  | pos_x/y/z, smoothing_length, inhibited, last
//  m_       | out       | m_valid / m_ready  | in_sightline, hits_so_far, batch_done
//  cfg_     | in        | cfg_we             | cfg_addr, cfg_wdata (no read-back)
//
//  One transaction at a time: accept, then 9 sequencer steps through the
//  single 32x32 multiplier (h*scale, three radius partials, two offset squares).
//  Reset (aresetn low, synchronous) clears sequencer, counter, output valid
//  and loads the register reset values.
//  The result sits in an output register; a new transaction is taken while it
//  waits, and the sequencer holds in its final step only if it is still full.
`default_nettype none

module sightline_particle_intersect_count #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input transactions
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [sic_pkg::DATA_W-1:0]   s_pos_x,
    input  wire logic [sic_pkg::DATA_W-1:0]   s_pos_y,
    input  wire logic [sic_pkg::DATA_W-1:0]   s_pos_z,
    input  wire logic [sic_pkg::DATA_W-1:0]   s_smoothing_length,
    input  wire logic                         s_inhibited,
    input  wire logic                         s_last,
    // result transactions
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_in_sightline,
    output logic [sic_pkg::DATA_W-1:0]        m_hits_so_far,
    output logic                              m_batch_done,
    // configuration writes
    input  wire logic                         cfg_we,
    input  wire logic [2:0]                   cfg_addr,
    input  wire logic [sic_pkg::DATA_W-1:0]   cfg_wdata
);

    // effective coordinate width: fields are 32 bits, masking only narrows
    localparam int CW = (COORD_BITS < sic_pkg::DATA_W) ? COORD_BITS : sic_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAD,     // h*scale; |pa - ca|
        ST_RADREG,  // latch radius; fold a
        ST_R00,     // r0*r0; |pb - cb|
        ST_R01,     // acc += r0r0; r0*r1; fold b
        ST_R11,     // acc += 2*r0r1; r1*r1
        ST_XX,      // acc += r1r1; ma*ma
        ST_YY,      // acc -= ma^2; mb*mb
        ST_LAST,    // acc -= mb^2
        ST_DONE     // decide, count, load result
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [sic_pkg::DATA_W-1:0]  center_first_reg, center_second_reg;
    logic [sic_pkg::DATA_W-1:0]  box_first_reg, box_second_reg;
    logic [sic_pkg::AXIS_W-1:0]  first_axis_reg, second_axis_reg;
    logic                        wrap_enable_reg;
    logic [sic_pkg::SCALE_W-1:0] smoothing_scale_reg;

    // captured transaction and working values
    logic [CW-1:0]                pa_reg, pb_reg;
    logic [sic_pkg::DATA_W-1:0]   h_reg;
    logic                         inh_reg, last_reg;
    logic [CW-1:0]                mag_a_reg, mag_b_reg;
    logic [sic_pkg::RAD_W-1:0]    rad_reg;

    logic [sic_pkg::DATA_W-1:0]   hit_count_reg, hit_count_next;
    logic                         m_valid_reg, m_in_sightline_reg, m_batch_done_reg;
    logic [sic_pkg::DATA_W-1:0]   m_hits_so_far_reg;

    logic s_fire, out_load, hit;

    // shared offset unit: absolute difference, used for offset and fold
    logic [CW-1:0] od_x, od_y, od_res;
    logic          fold_a, fold_b;

    logic [sic_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [sic_pkg::PROD_W-1:0] prod;
    logic                       acc_neg;
    sic_pkg::mac_ctrl_t         mac_ctrl;

    logic [sic_pkg::HALF_W-1:0] r0, r1;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign r0 = rad_reg[sic_pkg::HALF_W-1:0];
    assign r1 = rad_reg[sic_pkg::RAD_W-1:sic_pkg::HALF_W];

    // axis pick; selector 3 falls to z
    function automatic logic [CW-1:0] pick(
        input logic [sic_pkg::AXIS_W-1:0] sel,
        input logic [sic_pkg::DATA_W-1:0] x,
        input logic [sic_pkg::DATA_W-1:0] y,
        input logic [sic_pkg::DATA_W-1:0] z
    );
        logic [sic_pkg::DATA_W-1:0] v;
        if (sel == sic_pkg::AXIS_X) begin
            v = x;
        end else if (sel == sic_pkg::AXIS_Y) begin
            v = y;
        end else begin
            v = z;
        end
        return v[CW-1:0];
    endfunction

    always_comb begin
        case (state_reg)
            ST_RAD: begin
                od_x = pa_reg;
                od_y = center_first_reg[CW-1:0];
            end
            ST_RADREG: begin
                od_x = mag_a_reg;
                od_y = box_first_reg[CW-1:0];
            end
            ST_R00: begin
                od_x = pb_reg;
                od_y = center_second_reg[CW-1:0];
            end
            default: begin
                od_x = mag_b_reg;
                od_y = box_second_reg[CW-1:0];
            end
        endcase
        od_res = (od_x >= od_y) ? (od_x - od_y) : (od_y - od_x);
    end

    // fold when twice the magnitude exceeds the box; half box stays
    assign fold_a = wrap_enable_reg && ({mag_a_reg, 1'b0} > {1'b0, box_first_reg[CW-1:0]});
    assign fold_b = wrap_enable_reg && ({mag_b_reg, 1'b0} > {1'b0, box_second_reg[CW-1:0]});

    // multiplier operands and accumulate control per step
    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        mac_ctrl.op = sic_pkg::ACC_HOLD;
        mac_ctrl.sh = sic_pkg::SH_0;
        unique case (state_reg)
            ST_RAD: begin
                mul_a       = h_reg;
                mul_b       = sic_pkg::MUL_W'(smoothing_scale_reg);
                mac_ctrl.op = sic_pkg::ACC_CLEAR;
            end
            ST_R00: begin
                mul_a = sic_pkg::MUL_W'(r0);
                mul_b = sic_pkg::MUL_W'(r0);
            end
            ST_R01: begin
                mul_a       = sic_pkg::MUL_W'(r0);
                mul_b       = sic_pkg::MUL_W'(r1);
                mac_ctrl.op = sic_pkg::ACC_ADD;
                mac_ctrl.sh = sic_pkg::SH_0;
            end
            ST_R11: begin
                mul_a       = sic_pkg::MUL_W'(r1);
                mul_b       = sic_pkg::MUL_W'(r1);
                mac_ctrl.op = sic_pkg::ACC_ADD;
                mac_ctrl.sh = sic_pkg::SH_25;   // cross term counted twice
            end
            ST_XX: begin
                mul_a       = sic_pkg::MUL_W'(mag_a_reg);
                mul_b       = sic_pkg::MUL_W'(mag_a_reg);
                mac_ctrl.op = sic_pkg::ACC_ADD;
                mac_ctrl.sh = sic_pkg::SH_48;
            end
            ST_YY: begin
                mul_a       = sic_pkg::MUL_W'(mag_b_reg);
                mul_b       = sic_pkg::MUL_W'(mag_b_reg);
                mac_ctrl.op = sic_pkg::ACC_SUB;
                mac_ctrl.sh = sic_pkg::SH_24;   // offsets in Q.16, squared
            end
            ST_LAST: begin
                mac_ctrl.op = sic_pkg::ACC_SUB;
                mac_ctrl.sh = sic_pkg::SH_24;
            end
            default: begin
                mac_ctrl.op = sic_pkg::ACC_HOLD;
            end
        endcase
    end

    sic_mac u_mac (
        .aclk    (aclk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .ctrl    (mac_ctrl),
        .prod    (prod),
        .acc_neg (acc_neg)
    );

    // hit when not inhibited and rad^2 - (dx^2 + dy^2) is not negative
    assign hit = !inh_reg && !acc_neg;
    assign hit_count_next = (hit && (hit_count_reg != '1)) ? hit_count_reg + 1'b1
                                                           : hit_count_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire) state_next = ST_RAD;
            ST_RAD:    state_next = ST_RADREG;
            ST_RADREG: state_next = ST_R00;
            ST_R00:    state_next = ST_R01;
            ST_R01:    state_next = ST_R11;
            ST_R11:    state_next = ST_XX;
            ST_XX:     state_next = ST_YY;
            ST_YY:     state_next = ST_LAST;
            ST_LAST:   state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer, counter and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hit_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg   <= 1'b1;
                hit_count_reg <= last_reg ? '0 : hit_count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (out_load) begin
            m_in_sightline_reg <= hit;
            m_hits_so_far_reg  <= hit_count_next;
            m_batch_done_reg   <= last_reg;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_first_reg    <= '0;
            center_second_reg   <= '0;
            first_axis_reg      <= sic_pkg::AXIS_X;
            second_axis_reg     <= sic_pkg::AXIS_Y;
            box_first_reg       <= '0;
            box_second_reg      <= '0;
            wrap_enable_reg     <= 1'b0;
            smoothing_scale_reg <= sic_pkg::SCALE_RESET;
        end else if (cfg_we) begin
            unique case (sic_pkg::cfg_idx_t'(cfg_addr))
                sic_pkg::CFG_CENTER_FIRST:    center_first_reg  <= cfg_wdata;
                sic_pkg::CFG_CENTER_SECOND:   center_second_reg <= cfg_wdata;
                sic_pkg::CFG_FIRST_AXIS:
                    first_axis_reg <= cfg_wdata[sic_pkg::AXIS_W-1:0];
                sic_pkg::CFG_SECOND_AXIS:
                    second_axis_reg <= cfg_wdata[sic_pkg::AXIS_W-1:0];
                sic_pkg::CFG_BOX_FIRST:       box_first_reg     <= cfg_wdata;
                sic_pkg::CFG_BOX_SECOND:      box_second_reg    <= cfg_wdata;
                sic_pkg::CFG_WRAP_ENABLE:     wrap_enable_reg   <= cfg_wdata[0];
                sic_pkg::CFG_SMOOTHING_SCALE:
                    smoothing_scale_reg <= cfg_wdata[sic_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // transaction capture and working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pa_reg   <= pick(first_axis_reg, s_pos_x, s_pos_y, s_pos_z);
            pb_reg   <= pick(second_axis_reg, s_pos_x, s_pos_y, s_pos_z);
            h_reg    <= s_smoothing_length;
            inh_reg  <= s_inhibited;
            last_reg <= s_last;
        end
        case (state_reg)
            ST_RAD:    mag_a_reg <= od_res;
            ST_RADREG: begin
                rad_reg <= prod[sic_pkg::RAD_W-1:0];
                if (fold_a) mag_a_reg <= od_res;
            end
            ST_R00:    mag_b_reg <= od_res;
            ST_R01:    if (fold_b) mag_b_reg <= od_res;
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_in_sightline = m_in_sightline_reg;
    assign m_hits_so_far  = m_hits_so_far_reg;
    assign m_batch_done   = m_batch_done_reg;

`ifndef SYNTHESIS
    // a result cannot appear straight after an input transaction
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result raised one cycle after input transaction");

    // a hit always carries a non-zero count
    a_hit_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_sightline |-> m_hits_so_far != '0)
        else $error("hit reported with zero count");

    // count clears once the batch-closing result is loaded
    a_batch_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && last_reg |=> hit_count_reg == '0)
        else $error("hit counter not cleared after last transaction");

    // inhibited particles never hit
    a_inhibited: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && inh_reg |=> !m_in_sightline)
        else $error("inhibited particle reported as hit");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sic_mac.sv @@
// Shared registered multiplier with a signed shift-and-accumulate register.
`default_nettype none

module sic_mac (
    input  wire logic                      aclk,
    input  wire logic [sic_pkg::MUL_W-1:0] mul_a,
    input  wire logic [sic_pkg::MUL_W-1:0] mul_b,
    input  wire sic_pkg::mac_ctrl_t        ctrl,
    output logic [sic_pkg::PROD_W-1:0]     prod,
    output logic                           acc_neg
);

    logic [sic_pkg::PROD_W-1:0] prod_reg;
    logic [sic_pkg::ACC_W-1:0]  acc_reg;
    logic [sic_pkg::ACC_W-1:0]  prod_ext;
    logic [sic_pkg::ACC_W-1:0]  term;

    assign prod_ext = sic_pkg::ACC_W'(prod_reg);

    always_comb begin
        unique case (ctrl.sh)
            sic_pkg::SH_0:  term = prod_ext;
            sic_pkg::SH_24: term = prod_ext << 24;
            sic_pkg::SH_25: term = prod_ext << 25;
            sic_pkg::SH_48: term = prod_ext << 48;
            default:        term = prod_ext;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (ctrl.op)
            sic_pkg::ACC_CLEAR: acc_reg <= '0;
            sic_pkg::ACC_ADD:   acc_reg <= acc_reg + term;
            sic_pkg::ACC_SUB:   acc_reg <= acc_reg - term;
            default:            acc_reg <= acc_reg;
        endcase
    end

    assign prod    = prod_reg;
    assign acc_neg = acc_reg[sic_pkg::ACC_W-1];

endmodule

`default_nettype wire
